FILE: rtl/core/sm3_pkg.sv
`default_nettype none
package sm3_pkg;

    localparam logic [31:0] T_LOW = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;
    typedef logic [255:0] state_t;

    localparam state_t IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                             32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW = 2;

    // Kinds of words that the front part hands to the back part.
    typedef enum logic [1:0]
    {
        KIND_DATA,
        KIND_PAD,
        KIND_LEN,
        KIND_FINAL
    } kind_t;

    typedef struct packed
    {
        kind_t kind;
        word_t data;
    } qent_t;

    typedef enum logic [1:0]
    {
        BK_LOAD,
        BK_ROUND,
        BK_FOLD,
        BK_OUT
    } bk_state_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            return d[63:32];
        end
    endfunction

    function automatic word_t p0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t p1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sm3_front.sv
`default_nettype none
// Classifies incoming requests and expands the last word into padding words.
module sm3_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [31:0]    msg_word,
    input  wire logic [2:0]     byte_count,
    input  wire logic           last_word,
    output sm3_pkg::qent_t      q_data,
    output logic                q_valid,
    input  wire logic           q_ready
);

    logic        pad_reg, pad_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] len_reg, len_next;
    logic [1:0]  lenph_reg, lenph_next;
    logic        ext_reg, ext_next;
    logic [2:0]  cnt;
    logic [31:0] keep;

    assign cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign in_ready = !pad_reg && q_ready;

    always_comb
    begin
        keep = 32'hFFFFFFFF;
        unique case (cnt)
            3'd0: keep = 32'h00000000;
            3'd1: keep = 32'hFF000000;
            3'd2: keep = 32'hFFFF0000;
            3'd3: keep = 32'hFFFFFF00;
            default: keep = 32'hFFFFFFFF;
        endcase
    end

    always_comb
    begin
        pad_next = pad_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        lenph_next = lenph_reg;
        ext_next = ext_reg;
        q_valid = 1'b0;
        q_data.kind = sm3_pkg::KIND_DATA;
        q_data.data = msg_word;
        if (!pad_reg)
        begin
            q_valid = in_valid;
            if (last_word)
            begin
                if (cnt == 3'd4)
                begin
                    q_data.data = msg_word;
                    ext_next = 1'b1;
                end
                else
                begin
                    q_data.data = (msg_word & keep)
                                  | ({sm3_pkg::PAD_BYTE, 24'h0} >> {cnt, 3'b000});
                    ext_next = 1'b0;
                end
            end
            if (in_valid && q_ready)
            begin
                idx_next = idx_reg + 4'd1;
                if (last_word)
                begin
                    len_next = len_reg + {58'd0, cnt, 3'b000};
                    pad_next = 1'b1;
                    lenph_next = 2'd0;
                end
                else
                begin
                    len_next = len_reg + 64'd32;
                end
            end
        end
        else
        begin
            q_valid = 1'b1;
            if (ext_reg)
                q_data.data = {sm3_pkg::PAD_BYTE, 24'h0};
            else if (idx_reg == 4'd14)
                q_data.data = len_reg[63:32];
            else if (idx_reg == 4'd15 && lenph_reg == 2'd1)
                q_data.data = len_reg[31:0];
            else
                q_data.data = 32'h0;
            if (!ext_reg && idx_reg == 4'd15 && lenph_reg == 2'd1)
                q_data.kind = sm3_pkg::KIND_FINAL;
            else
                q_data.kind = sm3_pkg::KIND_PAD;
            if (q_ready)
            begin
                idx_next = idx_reg + 4'd1;
                ext_next = 1'b0;
                if (!ext_reg && idx_reg == 4'd14)
                    lenph_next = 2'd1;
                if (!ext_reg && idx_reg == 4'd15 && lenph_reg == 2'd1)
                begin
                    pad_next = 1'b0;
                    len_next = 64'd0;
                    idx_next = 4'd0;
                    lenph_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg <= 1'b0;
            idx_reg <= 4'd0;
            len_reg <= 64'd0;
            lenph_reg <= 2'd0;
            ext_reg <= 1'b0;
        end
        else
        begin
            pad_reg <= pad_next;
            idx_reg <= idx_next;
            len_reg <= len_next;
            lenph_reg <= lenph_next;
            ext_reg <= ext_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sm3_queue.sv
`default_nettype none
module sm3_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sm3_pkg::qent_t wr_data,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    output sm3_pkg::qent_t      rd_data,
    output logic                rd_valid,
    input  wire logic           rd_ready
);

    sm3_pkg::qent_t mem_reg [sm3_pkg::QDEPTH];
    logic [sm3_pkg::QAW:0] cnt_reg;
    logic [sm3_pkg::QAW-1:0] wp_reg, rp_reg;
    logic wr_en, rd_en;

    assign wr_ready = cnt_reg != sm3_pkg::QDEPTH[sm3_pkg::QAW:0];
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sm3_back.sv
`default_nettype none
// Collects 16 words, runs 64 rounds with a sliding 16-word expansion window.
module sm3_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sm3_pkg::qent_t q_data,
    input  wire logic           q_valid,
    output logic                q_ready,
    output logic [255:0]        digest,
    output logic                out_valid,
    input  wire logic           out_ready
);

    sm3_pkg::bk_state_t st_reg, st_next;
    logic [31:0] w_reg [16];
    logic [3:0]  idx_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [255:0] v_reg, r_reg, dig_reg;
    logic        ov_reg;

    logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
    logic take, last_in_blk, round_done;

    assign a = r_reg[255:224]; assign b = r_reg[223:192];
    assign c = r_reg[191:160]; assign d = r_reg[159:128];
    assign e = r_reg[127:96];  assign f = r_reg[95:64];
    assign g = r_reg[63:32];   assign h = r_reg[31:0];

    assign q_ready = (st_reg == sm3_pkg::BK_LOAD);
    assign take = q_valid && q_ready;
    assign last_in_blk = take && idx_reg == 4'd15;
    assign round_done = rnd_reg == 6'd63;
    assign out_valid = ov_reg;
    assign digest = dig_reg;

    always_comb
    begin
        t = sm3_pkg::rotl(rnd_reg < 6'd16 ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, rnd_reg[4:0]);
        a12 = sm3_pkg::rotl(a, 5'd12);
        ss1 = sm3_pkg::rotl(a12 + e + t, 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        else
        begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + h + ss1 + w_reg[0];
        wn = sm3_pkg::p1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rotl(w_reg[13], 5'd15))
             ^ sm3_pkg::rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            sm3_pkg::BK_LOAD:  if (last_in_blk) st_next = sm3_pkg::BK_ROUND;
            sm3_pkg::BK_ROUND: if (round_done) st_next = sm3_pkg::BK_FOLD;
            sm3_pkg::BK_FOLD:  st_next = fin_reg ? sm3_pkg::BK_OUT : sm3_pkg::BK_LOAD;
            sm3_pkg::BK_OUT:   if (!ov_reg || out_ready) st_next = sm3_pkg::BK_LOAD;
            default:           st_next = sm3_pkg::BK_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
            w_reg[idx_reg] <= q_data.data;
        else if (st_reg == sm3_pkg::BK_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
        end
        if (last_in_blk)
            r_reg <= v_reg;
        else if (st_reg == sm3_pkg::BK_ROUND)
            r_reg <= {tt1, a, sm3_pkg::rotl(b, 5'd9), c,
                      sm3_pkg::p0(tt2), e, sm3_pkg::rotl(f, 5'd19), g};
        if (st_reg == sm3_pkg::BK_OUT && (!ov_reg || out_ready))
            dig_reg <= v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= sm3_pkg::BK_LOAD;
            idx_reg <= 4'd0;
            rnd_reg <= 6'd0;
            fin_reg <= 1'b0;
            v_reg <= sm3_pkg::IV;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (take)
            begin
                idx_reg <= idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                    fin_reg <= q_data.kind == sm3_pkg::KIND_FINAL;
            end
            if (st_reg == sm3_pkg::BK_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (st_reg == sm3_pkg::BK_FOLD)
                v_reg <= v_reg ^ r_reg;
            if (st_reg == sm3_pkg::BK_OUT && (!ov_reg || out_ready))
            begin
                ov_reg <= 1'b1;
                v_reg <= sm3_pkg::IV;
            end
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sm3_hash_engine.sv
`default_nettype none
// SM3 hash engine.
// The slave channel takes one message word per request: tdata carries msg_word
// in bits 31..0 (first byte in 31..24) and byte_count in bits 34..32, and tlast
// marks the final word of a message. Words that are not last count four bytes.
// The master channel gives one 256-bit digest per message after its last word,
// packed as digest_hi, digest_mid_hi, digest_mid_lo, digest_lo from bit 0 up.
// Words pass through a four-entry queue to the compression unit, which does one
// round per cycle: each 16-word block is loaded, then takes 64 rounds and a
// fold, and the unit takes no new words until that block is through. The last
// word adds padding words that fill out its block and at most one more block;
// after the rounds and fold of the final block, the output state loads the digest.
// A finished digest waits in an output register while the next message is
// loaded; a stalled receiver only holds the unit at the end of the following
// message. Reset loads the initial vector and clears lengths.
module sm3_hash_engine
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [39:0]    s_axis_tdata,   // msg_word, byte_count, zero fill
    input  wire logic           s_axis_tlast,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [255:0]        m_axis_tdata    // digest_hi, mid_hi, mid_lo, lo
);

    sm3_pkg::qent_t fq_data, bq_data;
    logic fq_valid, fq_ready, bq_valid, bq_ready;
    logic [255:0] dig;

    sm3_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .msg_word(s_axis_tdata[31:0]), .byte_count(s_axis_tdata[34:32]),
        .last_word(s_axis_tlast),
        .q_data(fq_data), .q_valid(fq_valid), .q_ready(fq_ready)
    );

    sm3_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_data(fq_data), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .rd_data(bq_data), .rd_valid(bq_valid), .rd_ready(bq_ready)
    );

    sm3_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_data(bq_data), .q_valid(bq_valid), .q_ready(bq_ready),
        .digest(dig), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {dig[63:0], dig[127:64], dig[191:128], dig[255:192]};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed while stalled");
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        !fq_ready |-> !s_axis_tready)
        else $error("request accepted with queue full");

endmodule
`default_nettype wire

FILE: dv/tb_sm3_hash_engine.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_sm3_hash_engine;

    localparam int unsigned RANDOM_WORDS = 650;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        logic [63:0] hi;
        logic [63:0] mid_hi;
        logic [63:0] mid_lo;
        logic [63:0] lo;
    } digest_t;

    typedef struct
    {
        logic [31:0] word;
        logic [2:0] count;
        logic last;
        bit has_digest;
        digest_t digest;
    } msg_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [255:0] m_axis_tdata;

    sm3_hash_engine dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    sm3_pkg::word_t chain_v [8];
    sm3_pkg::word_t blk [16];
    int unsigned blk_fill;
    logic [63:0] bit_len;
    digest_t digest_queue [$];
    int unsigned error_count;
    int unsigned digest_count;
    int unsigned cycle_count;
    int unsigned word_count;
    bit hold_off;
    bit stim_done;
    msg_row_t rows [$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic sm3_pkg::word_t rol(input sm3_pkg::word_t x, input int unsigned n);
        int unsigned s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic reset_chain();
        for (int i = 0; i < 8; i++)
            chain_v[i] = sm3_pkg::IV[255 - 32 * i -: 32];
        blk_fill = 0;
        bit_len = 64'd0;
    endtask

    task automatic compress();
        sm3_pkg::word_t w [68];
        sm3_pkg::word_t r [8];
        sm3_pkg::word_t t, a12, ss1, ss2, ff, gg, tt1, tt2, x;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 68; i++)
        begin
            x = w[i - 16] ^ w[i - 9] ^ rol(w[i - 3], 15);
            w[i] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[i - 13], 7) ^ w[i - 6];
        end
        for (int i = 0; i < 8; i++)
            r[i] = chain_v[i];
        for (int j = 0; j < 64; j++)
        begin
            t = rol(j < 16 ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, j);
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + t, 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[j] ^ w[j + 4]);
            tt2 = gg + r[7] + ss1 + w[j];
            r[3] = r[2];
            r[2] = rol(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rol(r[5], 19);
            r[5] = r[4];
            r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        for (int i = 0; i < 8; i++)
            chain_v[i] ^= r[i];
    endtask

    task automatic push_block_word(input sm3_pkg::word_t v);
        blk[blk_fill] = v;
        blk_fill = (blk_fill + 1) % 16;
        if (blk_fill == 0)
            compress();
    endtask

    task automatic predict_word(input logic [31:0] word, input logic [2:0] count,
                                input logic last);
        int unsigned n;
        sm3_pkg::word_t keep;
        digest_t d;
        if (!last)
        begin
            bit_len += 64'd32;
            push_block_word(word);
            return;
        end
        n = (count > 4) ? 4 : count;
        bit_len += 64'(8 * n);
        if (n == 4)
        begin
            push_block_word(word);
            push_block_word({sm3_pkg::PAD_BYTE, 24'd0});
        end
        else
        begin
            keep = (n == 0) ? 32'd0 : (32'hFFFFFFFF << (32 - 8 * n));
            push_block_word((word & keep) | ({sm3_pkg::PAD_BYTE, 24'd0} >> (8 * n)));
        end
        while (blk_fill != 14)
            push_block_word(32'd0);
        push_block_word(bit_len[63:32]);
        push_block_word(bit_len[31:0]);
        d.hi = {chain_v[0], chain_v[1]};
        d.mid_hi = {chain_v[2], chain_v[3]};
        d.mid_lo = {chain_v[4], chain_v[5]};
        d.lo = {chain_v[6], chain_v[7]};
        digest_queue.insert(digest_queue.size(), d);
        reset_chain();
    endtask

    task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                             input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, count, word};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_word(word, count, last);
        word_count++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [31:0] word, input logic [2:0] count,
                           input logic last, input bit known, input digest_t d);
        msg_row_t r;
        r.word = word;
        r.count = count;
        r.last = last;
        r.has_digest = known;
        r.digest = d;
        rows.insert(rows.size(), r);
    endtask

    task automatic random_gap();
        int unsigned g;
        if ($urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            digest_t got, want;
            got = {m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tdata[191:128],
                   m_axis_tdata[255:192]};
            if (digest_queue.size() == 0)
            begin
                $error("digest with no message pending: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = digest_queue.pop_front();
                if (got.hi !== want.hi)
                begin
                    $error("digest_hi expected %h got %h", want.hi, got.hi);
                    error_count++;
                end
                if (got.mid_hi !== want.mid_hi)
                begin
                    $error("digest_mid_hi expected %h got %h", want.mid_hi, got.mid_hi);
                    error_count++;
                end
                if (got.mid_lo !== want.mid_lo)
                begin
                    $error("digest_mid_lo expected %h got %h", want.mid_lo, got.mid_lo);
                    error_count++;
                end
                if (got.lo !== want.lo)
                begin
                    $error("digest_lo expected %h got %h", want.lo, got.lo);
                    error_count++;
                end
            end
            digest_count++;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 9) < 7) || (cycle_count % 512 < 100);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        hold_off = 1'b0;
        #1;
        forever
        begin
            @(posedge clk);
            if (word_count > 200)
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
                break;
            end
        end
    end

    initial
    begin
        digest_t known_abc, none;
        logic [31:0] w;
        logic [2:0] c;
        int unsigned len;
        error_count = 0;
        digest_count = 0;
        cycle_count = 0;
        word_count = 0;
        stim_done = 1'b0;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        reset_chain();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Published test vector: "abc".
        known_abc = {64'h66c7f0f462eeedd9, 64'hd1f2d46bdc10e4e2,
                     64'h4167c4875cf2f7a2, 64'h297da02b8f4ba8e0};
        add_row(32'h61626300, 3'd3, 1'b1, 1'b1, known_abc);
        add_row(32'h00000000, 3'd0, 1'b1, 1'b0, none);
        add_row(32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, none);
        add_row(32'hFFFFFFFF, 3'd1, 1'b1, 1'b0, none);
        add_row(32'hFFFFFFFF, 3'd2, 1'b1, 1'b0, none);
        add_row(32'hFFFFFFFF, 3'd7, 1'b1, 1'b0, none);
        add_row(32'hFFFFFFFF, 3'd5, 1'b1, 1'b0, none);
        for (int i = 0; i < 13; i++)
            add_row(32'hFFFFFFFF - i, 3'd0, 1'b0, 1'b0, none);
        add_row(32'hA5A5A5A5, 3'd4, 1'b1, 1'b0, none);
        add_row(32'h00000000, 3'd7, 1'b0, 1'b0, none);
        add_row(32'h12345678, 3'd6, 1'b1, 1'b0, none);

        foreach (rows[i])
        begin
            send_word(rows[i].word, rows[i].count, rows[i].last);
            if (rows[i].has_digest && digest_queue.size() > 0
                && digest_queue[digest_queue.size() - 1] != rows[i].digest)
            begin
                $error("digest expected %h predicted %h", rows[i].digest,
                       digest_queue[digest_queue.size() - 1]);
                error_count++;
            end
        end

        while (word_count < RANDOM_WORDS + rows.size())
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(14, 40);
            else
                len = $urandom_range(0, 8);
            for (int k = 0; k < len; k++)
            begin
                random_gap();
                w = $urandom;
                c = $urandom_range(0, 7);
                send_word(w, c, 1'b0);
            end
            random_gap();
            w = $urandom;
            c = $urandom_range(0, 7);
            send_word(w, c, 1'b1);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d message words; %0d digests checked, including held-off output.",
                 word_count, digest_count);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
